// ----- rtl/gbs_pkg.sv -----
package gbs_pkg;

   // Default sizes of the retained table and of a coordinate.
   localparam int MAX_KEPT_DEF    = 64;
   localparam int COORD_WIDTH_DEF = 16;

   // Fixed field widths.
   localparam int DIM_W  = 15;              // box width and height
   localparam int AREA_W = 2 * DIM_W;       // width * height
   localparam int SUM_W  = AREA_W + 1;      // sum of two areas
   localparam int THR_W  = 8;               // overlap-over-union limit
   localparam int SLOT_W = 6;               // reported slot number
   localparam int RSP_W  = 8;               // result tdata width

   localparam logic [THR_W-1:0] THR_RESET = 8'd115;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } gbs_state_type;

   // Data handed from one cell to the next. The box front is marked by act;
   // the later phases trail it by one, two and three cells.
   typedef struct packed {
      logic              act;
      logic              b_live;
      logic [DIM_W-1:0]  b_iw;
      logic [DIM_W-1:0]  b_ih;
      logic [AREA_W-1:0] b_karea;
      logic              c_live;
      logic [AREA_W-1:0] c_inter;
      logic [SUM_W-1:0]  c_sum;
      logic              d_live;
      logic [AREA_W-1:0] d_inter;
      logic [SUM_W-1:0]  d_uni;
      logic              sup;
   } gbs_link_type;

endpackage

// ----- rtl/gbs_cell.sv -----
module gbs_cell import gbs_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int MAX_KEPT    = MAX_KEPT_DEF,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(MAX_KEPT+1)-1:0] kept_count,
   input  logic [THR_W-1:0]              thr,
   input  logic signed [COORD_WIDTH-1:0] box_left,
   input  logic signed [COORD_WIDTH-1:0] box_top,
   input  logic [DIM_W-1:0]              box_width,
   input  logic [DIM_W-1:0]              box_height,
   input  logic [AREA_W-1:0]             box_area,
   input  logic                          wr_en,
   input  logic [((MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1)-1:0] wr_slot,
   input  gbs_link_type                  up_link,
   output gbs_link_type                  down_link
);

   localparam int SPAN_W = ((COORD_WIDTH > DIM_W) ? COORD_WIDTH : DIM_W + 1) + 1;
   localparam int PROD_W = THR_W + SUM_W;

   // Overlap length on one axis, zero when the spans only touch or miss.
   function automatic logic [DIM_W-1:0] span_overlap(
      input logic signed [COORD_WIDTH-1:0] a0,
      input logic [DIM_W-1:0]              aw,
      input logic signed [COORD_WIDTH-1:0] b0,
      input logic [DIM_W-1:0]              bw
   );
      logic signed [SPAN_W-1:0] a_lo, a_hi, b_lo, b_hi, lo, hi, d;
      a_lo = SPAN_W'(a0);
      b_lo = SPAN_W'(b0);
      a_hi = a_lo + $signed(SPAN_W'(aw));
      b_hi = b_lo + $signed(SPAN_W'(bw));
      lo   = (a_lo > b_lo) ? a_lo : b_lo;
      hi   = (a_hi < b_hi) ? a_hi : b_hi;
      d    = hi - lo;
      return (d > 0) ? DIM_W'(d) : '0;
   endfunction

   logic signed [COORD_WIDTH-1:0] ent_left_ff;
   logic signed [COORD_WIDTH-1:0] ent_top_ff;
   logic [DIM_W-1:0]              ent_width_ff;
   logic [DIM_W-1:0]              ent_height_ff;
   logic [AREA_W-1:0]             ent_area_ff;
   gbs_link_type                  link_in;
   gbs_link_type                  link_ff;
   logic                          live;
   logic [PROD_W-1:0]             prod;
   logic [PROD_W-1:0]             scaled;
   logic                          hit;

   // The stored entry takes part only while it lies below the fill count.
   assign live = up_link.act && (32'(kept_count) > INDEX);

   // Final test for the entry three cells back.
   assign prod   = PROD_W'(thr) * PROD_W'(up_link.d_uni);
   assign scaled = PROD_W'({up_link.d_inter, {THR_W{1'b0}}});
   assign hit    = up_link.d_live && (scaled > prod);

   // Spans for this entry, intersection and union for the ones behind.
   always_comb begin
      link_in         = up_link;
      link_in.b_live  = live;
      link_in.b_iw    = span_overlap(box_left, box_width, ent_left_ff, ent_width_ff);
      link_in.b_ih    = span_overlap(box_top, box_height, ent_top_ff, ent_height_ff);
      link_in.b_karea = ent_area_ff;
      link_in.c_live  = up_link.b_live;
      link_in.c_inter = AREA_W'(AREA_W'(up_link.b_iw) * AREA_W'(up_link.b_ih));
      link_in.c_sum   = SUM_W'(box_area) + SUM_W'(up_link.b_karea);
      link_in.d_live  = up_link.c_live;
      link_in.d_inter = up_link.c_inter;
      link_in.d_uni   = up_link.c_sum - SUM_W'(up_link.c_inter);
      link_in.sup     = up_link.sup | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in;
      end
   end

   // A retained box is written into the cell whose slot it was given.
   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_slot) == INDEX)) begin
         ent_left_ff   <= box_left;
         ent_top_ff    <= box_top;
         ent_width_ff  <= box_width;
         ent_height_ff <= box_height;
         ent_area_ff   <= box_area;
      end
   end

   assign down_link = link_ff;

endmodule

// ----- rtl/greedy_box_suppression_top.sv -----
// Greedy box suppression.
// Boxes enter on the req_ stream sorted by falling score, one transaction per
// box: left, top, width and height in tdata and the first-of-frame mark in
// tuser. A first-of-frame box empties the retained table before it is tested.
// Every box yields exactly one rsp_ transaction: retained, slot and overflow.
// The overlap-over-union limit is written on csr_wr_en/csr_wr_data while the
// block is idle, a rule for the user that the block does not enforce; it resets
// to 115/256. Each box walks a row of MAX_KEPT + 3 cells, one cell per cycle;
// each of the first MAX_KEPT cells holds one retained box and tests the passing
// box against it in four trailing phases. The decision is registered when the
// box front leaves the last cell and then moves to the output register; only
// then is the next box taken, so boxes are tested one at a time.
// A box is accepted while an earlier result still waits in the output
// register; if the receiver stalls, the finished result of that box is held
// until the output register frees, and no further box is taken meanwhile.
// Reset empties the table, clears both channels and restores the limit.
module greedy_box_suppression_top import gbs_pkg::*; #(
   parameter int MAX_KEPT    = MAX_KEPT_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // Fields from bit 0 up: box_left, box_top, box_width, box_height.
   input  logic [((2*COORD_WIDTH+2*DIM_W+7)/8)*8-1:0] req_tdata,
   // Field: first_of_frame.
   input  logic                    req_tuser,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // Fields from bit 0 up: retained, slot, overflow.
   output logic [RSP_W-1:0]        rsp_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_wr_en,
   input  logic [THR_W-1:0]        csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int NCELL = MAX_KEPT + 3;
   localparam int CW    = COORD_WIDTH;

   gbs_state_type           state_ff, state_in;
   logic [THR_W-1:0]        thr_ff;
   logic signed [CW-1:0]    box_left_ff;
   logic signed [CW-1:0]    box_top_ff;
   logic [DIM_W-1:0]        box_width_ff;
   logic [DIM_W-1:0]        box_height_ff;
   logic [AREA_W-1:0]       box_area_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    launch_ff;
   logic [RSP_W-1:0]        res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                    req_accept;
   logic                    keep;
   logic                    room;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_slot;
   logic [DIM_W-1:0]        in_width;
   logic [DIM_W-1:0]        in_height;
   gbs_link_type            link [0:NCELL];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign in_width   = req_tdata[2*CW+DIM_W-1:2*CW];
   assign in_height  = req_tdata[2*CW+2*DIM_W-1:2*CW+DIM_W];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // The accepted box is held and broadcast to all cells while it is tested.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         box_left_ff   <= req_tdata[CW-1:0];
         box_top_ff    <= req_tdata[2*CW-1:CW];
         box_width_ff  <= in_width;
         box_height_ff <= in_height;
         box_area_ff   <= AREA_W'(AREA_W'(in_width) * AREA_W'(in_height));
      end
   end

   // Decision when the box front leaves the last cell.
   assign keep    = !link[NCELL].sup;
   assign room    = (32'(count_ff) < MAX_KEPT);
   assign wr_en   = (state_ff == ST_RUN) && link[NCELL].act && keep && room;
   assign wr_slot = IDX_W'(count_ff);

   // Sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser) begin
                  count_in = '0;
               end
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (link[NCELL].act) begin
               res_in[0] = keep;
               res_in[SLOT_W:1] = wr_en ? SLOT_W'(count_ff) : '0;
               res_in[SLOT_W+1] = keep && !room;
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         launch_ff    <= req_accept;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Row of cells; the tail cells past the table finish the trailing phases.
   always_comb begin
      link[0]     = '0;
      link[0].act = launch_ff;
   end

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      gbs_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .MAX_KEPT    (MAX_KEPT),
         .INDEX       (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .kept_count (count_ff),
         .thr        (thr_ff),
         .box_left   (box_left_ff),
         .box_top    (box_top_ff),
         .box_width  (box_width_ff),
         .box_height (box_height_ff),
         .box_area   (box_area_ff),
         .wr_en      (wr_en),
         .wr_slot    (wr_slot),
         .up_link    (link[g]),
         .down_link  (link[g+1])
      );
   end

   // The fill count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_KEPT)
      else $error("retained count beyond table size");

   // A table write always finds a free slot and bumps the count.
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("table write without count update");

   // The box front reaches the end of the row only while a box is tested.
   a_front_run: assert property (@(posedge clock) disable iff (reset)
      link[NCELL].act |-> (state_ff == ST_RUN))
      else $error("box front outside of a test");

   // A suppressed box reports neither a slot nor an overflow.
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[0]) |-> (rsp_data_ff[RSP_W-1:1] == '0))
      else $error("suppressed box with slot or overflow");

endmodule

// ----- bench/tb_greedy_box_suppression_top.sv -----
module tb_greedy_box_suppression_top;
   import gbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_KEPT       = MAX_KEPT_DEF;
   localparam int REQ_W          = ((2 * COORD_WIDTH_DEF + 2 * DIM_W + 7) / 8) * 8;
   localparam int ITEM_TARGET    = 1450;
   localparam int HOLDOFF_CYCLES = 600;
   localparam int CFG_SPACING    = 240;
   localparam int CYCLE_LIMIT    = 1_500_000;

   // One box as it travels on the request stream.
   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic               first;
   } box_type;

   // One suppression verdict as it travels on the response stream.
   typedef struct {
      logic              retained;
      logic [SLOT_W-1:0] slot;
      logic              overflow;
   } verdict_type;

   // Predicts the verdict of every accepted box and checks the verdicts that come back.
   class suppression_scoreboard_type;
      longint unsigned iou_limit;
      longint          kept_left   [MAX_KEPT];
      longint          kept_top    [MAX_KEPT];
      longint          kept_width  [MAX_KEPT];
      longint          kept_height [MAX_KEPT];
      longint unsigned kept_area   [MAX_KEPT];
      int unsigned     kept_count;
      verdict_type     expected_verdicts[$];
      int unsigned     mismatches;

      function new();
         iou_limit  = THR_RESET;
         kept_count = 0;
         mismatches = 0;
      endfunction

      // Length that two spans share on one axis; touching spans share nothing.
      function longint axis_overlap(longint a0, longint aw, longint b0, longint bw);
         longint a1;
         longint b1;
         longint lo;
         longint hi;
         a1 = a0 + aw;
         b1 = b0 + bw;
         if (a0 > b1 || a1 < b0) return 0;
         lo = (a0 > b0) ? a0 : b0;
         hi = (a1 < b1) ? a1 : b1;
         return (hi > lo) ? hi - lo : 0;
      endfunction

      // Greedy test of a new box against every retained box, then table update.
      function verdict_type predict_verdict(box_type b);
         verdict_type     v;
         longint          left;
         longint          top;
         longint          w;
         longint          h;
         longint unsigned area;
         longint unsigned inter;
         longint unsigned joint_area;
         bit              keep;
         left = b.left;
         top  = b.top;
         w    = b.width;
         h    = b.height;
         area = longint'(w * h);
         keep = 1'b1;
         if (b.first) kept_count = 0;
         for (int j = 0; j < kept_count; j++) begin
            inter = longint'(axis_overlap(left, w, kept_left[j], kept_width[j]) *
                             axis_overlap(top, h, kept_top[j], kept_height[j]));
            joint_area = area + kept_area[j] - inter;
            if (inter * 256 > iou_limit * joint_area) keep = 1'b0;
         end
         v.retained = keep;
         v.slot     = '0;
         v.overflow = 1'b0;
         if (keep) begin
            if (kept_count < MAX_KEPT) begin
               kept_left[kept_count]   = left;
               kept_top[kept_count]    = top;
               kept_width[kept_count]  = w;
               kept_height[kept_count] = h;
               kept_area[kept_count]   = area;
               v.slot = kept_count[SLOT_W-1:0];
               kept_count++;
            end else begin
               v.overflow = 1'b1;
            end
         end
         return v;
      endfunction

      function void note_box(box_type b);
         expected_verdicts.insert(expected_verdicts.size(), predict_verdict(b));
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_verdict(logic [RSP_W-1:0] data);
         verdict_type exp_v;
         string       exp_s;
         if (expected_verdicts.size() == 0) begin
            report($sformatf("verdict 0x%02h arrived with no box pending", data));
            return;
         end
         exp_v = expected_verdicts.pop_front();
         if (exp_v.retained !== data[0] || exp_v.slot !== data[SLOT_W:1] ||
             exp_v.overflow !== data[SLOT_W+1]) begin
            exp_s = $sformatf("expected retained=%0d slot=%0d overflow=%0d",
                              exp_v.retained, exp_v.slot, exp_v.overflow);
            report($sformatf("verdict differs: %s, got retained=%0d slot=%0d overflow=%0d",
                             exp_s, data[0], data[SLOT_W:1], data[SLOT_W+1]));
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic [REQ_W-1:0]   req_tdata;
   logic               req_tuser;
   logic               req_tvalid;
   logic               req_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic               csr_wr_en;
   logic [THR_W-1:0]   csr_wr_data;

   suppression_scoreboard_type board;
   int unsigned                boxes_sent;
   int unsigned                cycle_count;
   bit                         send_idle_on;
   bit                         rsp_idle_on;
   bit                         holdoff_req;

   greedy_box_suppression_top #(
      .MAX_KEPT    (MAX_KEPT),
      .COORD_WIDTH (COORD_WIDTH_DEF)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // Builds a box, wrapping coordinates and clipping sizes to the field ranges.
   function box_type make_box(int l, int t, int w, int h, bit first);
      box_type b;
      b.left   = l[15:0];
      b.top    = t[15:0];
      b.width  = (w < 0) ? '0 : (w > 32767) ? 15'h7fff : w[DIM_W-1:0];
      b.height = (h < 0) ? '0 : (h > 32767) ? 15'h7fff : h[DIM_W-1:0];
      b.first  = first;
      return b;
   endfunction

   // Offers one box after an optional gap and waits for its transaction.
   task automatic send_box(input box_type b, input int gap);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, b.height, b.width, b.top, b.left};
      req_tuser  = b.first;
      do @(posedge clock); while (!req_tready);
      board.note_box(b);
      boxes_sent++;
   endtask

   task automatic send_directed(input int l, input int t, input int w, input int h,
                                input bit first);
      send_box(make_box(l, t, w, h, first), send_idle_on ? pick_gap() : 0);
   endtask

   // The sender pauses until every outstanding verdict has come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // Writes the overlap limit with the block idle.
   task automatic set_iou_limit(input logic [THR_W-1:0] value);
      drain_results();
      repeat (10) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      board.iou_limit = value;
   endtask

   // A frame of boxes gathered around a few objects, so that many overlap.
   task automatic send_cluster_frame(input int count, input bit open_frame);
      int      cx[4];
      int      cy[4];
      int      cw[4];
      int      ch[4];
      int      nc;
      int      c;
      box_type b;
      nc = $urandom_range(1, 4);
      for (int i = 0; i < nc; i++) begin
         cx[i] = int'($urandom_range(0, 60000)) - 30000;
         cy[i] = int'($urandom_range(0, 60000)) - 30000;
         cw[i] = $urandom_range(64, 4000);
         ch[i] = $urandom_range(64, 4000);
      end
      for (int k = 0; k < count; k++) begin
         c = $urandom_range(0, nc - 1);
         b = make_box(cx[c] + int'($urandom_range(0, 2 * (cw[c] / 3))) - cw[c] / 3,
                      cy[c] + int'($urandom_range(0, 2 * (ch[c] / 3))) - ch[c] / 3,
                      cw[c] + int'($urandom_range(0, cw[c] / 2)) - cw[c] / 4,
                      ch[c] + int'($urandom_range(0, ch[c] / 2)) - ch[c] / 4,
                      open_frame && (k == 0));
         send_box(b, send_idle_on ? pick_gap() : 0);
      end
   endtask

   // Raw boxes with every field drawn over its whole range.
   task automatic send_noise(input int count);
      box_type b;
      for (int k = 0; k < count; k++) begin
         b.left   = 16'($urandom);
         b.top    = 16'($urandom);
         b.width  = DIM_W'($urandom);
         b.height = DIM_W'($urandom);
         b.first  = ($urandom_range(0, 7) == 0);
         send_box(b, send_idle_on ? pick_gap() : 0);
      end
   endtask

   // Disjoint boxes on a grid fill the table past its end; a copy of the
   // first box closes the frame and must be suppressed even with a full table.
   task automatic send_fill_frame();
      int      count;
      box_type b;
      box_type head;
      count = MAX_KEPT + $urandom_range(1, 6);
      for (int k = 0; k < count; k++) begin
         b = make_box(-32000 + (k % 16) * 3000, -32000 + (k / 16) * 3000,
                      $urandom_range(100, 2500), $urandom_range(100, 2500), k == 0);
         if (k == 0) head = b;
         send_box(b, send_idle_on ? pick_gap() : 0);
      end
      head.first = 1'b0;
      send_box(head, 0);
   endtask

   // Response side: random back-pressure plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            rsp_tready  = 1'b0;
            repeat (HOLDOFF_CYCLES - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (rsp_idle_on) stall_left = pick_gap();
         end
      end
   end

   // Every verdict transaction is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Main sequence: reset, directed boxes, random frames, drain and verdict.
   initial begin
      int unsigned next_cfg;
      int          cfg_phase;
      int          r;
      bit          pressure_done;
      board        = new();
      boxes_sent   = 0;
      cycle_count  = 0;
      send_idle_on = 1'b1;
      rsp_idle_on  = 1'b1;
      holdoff_req  = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed boxes at the reset limit: duplicates, touching edges,
      // empty boxes, zero union, field extremes and a new frame.
      send_directed(0, 0, 160, 160, 1);
      send_directed(0, 0, 160, 160, 0);
      send_directed(160, 0, 160, 160, 0);
      send_directed(0, 160, 160, 160, 0);
      send_directed(0, 0, 0, 0, 0);
      send_directed(0, 0, 0, 0, 0);
      send_directed(40, 0, 160, 160, 0);
      send_directed(-32768, -32768, 32767, 32767, 0);
      send_directed(32767, 32767, 32767, 32767, 0);
      send_directed(0, 0, 32767, 32767, 0);
      send_directed(-32768, 32767, 0, 32767, 0);
      send_directed(32767, -32768, 32767, 0, 0);
      send_directed(5, 5, 150, 150, 1);
      send_directed(300, 300, 100, 100, 0);

      // Lowest limit: any real overlap suppresses.
      set_iou_limit(8'd0);
      send_directed(10, 10, 150, 150, 1);
      send_directed(155, 10, 100, 100, 0);
      send_directed(500, 500, 10, 10, 0);

      // Highest limit: only a nearly exact copy suppresses.
      set_iou_limit(8'd255);
      send_directed(10, 10, 150, 150, 1);
      send_directed(10, 10, 150, 150, 0);
      send_directed(11, 10, 150, 150, 0);

      // Random frames, with the limit changed between phases.
      set_iou_limit(THR_RESET);
      next_cfg      = boxes_sent + CFG_SPACING;
      cfg_phase     = 0;
      pressure_done = 1'b0;
      while (boxes_sent < ITEM_TARGET) begin
         send_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on  = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (!pressure_done && boxes_sent >= 700) begin
            // Long receiver hold-off while boxes keep coming back to back.
            pressure_done = 1'b1;
            send_idle_on  = 1'b0;
            holdoff_req   = 1'b1;
            send_cluster_frame(24, 1);
            drain_results();
         end else if (r < 66) begin
            send_cluster_frame($urandom_range(3, 40), 1);
         end else if (r < 78) begin
            send_cluster_frame($urandom_range(2, 12), 0);
         end else if (r < 95) begin
            send_noise($urandom_range(1, 8));
         end else begin
            send_fill_frame();
         end
         if (boxes_sent >= next_cfg) begin
            case (cfg_phase % 5)
               0: set_iou_limit(THR_W'($urandom_range(0, 255)));
               1: set_iou_limit(8'd0);
               2: set_iou_limit(THR_W'($urandom_range(60, 180)));
               3: set_iou_limit(8'd255);
               default: set_iou_limit(THR_RESET);
            endcase
            cfg_phase++;
            next_cfg = boxes_sent + CFG_SPACING;
         end
      end

      // Let every verdict come back, then allow for anything stray.
      drain_results();
      repeat (MAX_KEPT + 20) @(posedge clock);
      if (board.mismatches == 0 && board.expected_verdicts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gbs_pkg.sv
rtl/gbs_cell.sv
rtl/greedy_box_suppression_top.sv
bench/tb_greedy_box_suppression_top.sv
